// ===== rtl/bml_pkg.sv =====
`timescale 1ns / 1ps

package bml_pkg;

  localparam int XW = 32;
  localparam int OW = 14;

  localparam int PRIME_DEF      = 10007;
  localparam int MAX_DIGITS_DEF = 3;

  typedef enum logic [3:0] {
    OP_FACT,
    OP_PACC,
    OP_PSQ,
    OP_INVF,
    OP_DIVN,
    OP_DIVK,
    OP_MA,
    OP_MB,
    OP_MC
  } op_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_FACT_ISSUE,
    ST_FACT_WAIT,
    ST_POW_INIT,
    ST_POW_CHECK,
    ST_POW_SQ,
    ST_POW_WAIT,
    ST_SEED,
    ST_INVF_ISSUE,
    ST_INVF_WAIT,
    ST_IDLE,
    ST_DIG_CHECK,
    ST_DIV_K,
    ST_DIV_WAIT,
    ST_READ,
    ST_MUL_AB,
    ST_MUL_B,
    ST_MUL_WAIT1,
    ST_MUL_C,
    ST_MUL_WAIT2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic init;
    logic idx_inc;
    logic idx_dec;
    logic pow_init;
    logic e_shift;
    logic seed;
    logic load;
    logic acc_zero;
    logic rd;
    logic out_load;
    logic issue;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic idx_last;
    logic idx_one;
    logic e_zero;
    logic e_bit0;
    logic k_zero;
    logic kd_gt_nd;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/binomial_mod_prime_lucas_unit.sv =====
`timescale 1ns / 1ps

// Binomial coefficient C(n,k) mod PRIME by Lucas's theorem. After reset the
// unit builds its factorial and inverse-factorial tables (one PRIME-entry
// memory each) and holds in_stall high until they are done. Items are then
// taken one at a time. All arithmetic runs on one shared pipelined multiply /
// divide-by-PRIME unit, through the s0 register and the divider's s1 and s2
// registers to write-back; each base-PRIME digit costs a division step for n
// and k, a table read and three modular products (the last one waits for the
// other two). An item ends when D digits have been multiplied (up to
// MAX_DIGITS, stopping when the remaining k is zero), or early with a zero
// result when the digit after those D has k above n; it then waits in ST_DONE
// while a stalled output register is still full. The next item is accepted
// while the previous result still waits in the output register.
module binomial_mod_prime_lucas_unit #(
  parameter int PRIME      = bml_pkg::PRIME_DEF,
  parameter int MAX_DIGITS = bml_pkg::MAX_DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [bml_pkg::XW-1:0] n_value,
  input  logic [bml_pkg::XW-1:0] k_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [bml_pkg::OW-1:0] binom_mod
);

  bml_pkg::cmd_t    cmd;
  bml_pkg::status_t status;

  bml_ctrl #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .status  (status)
  );

  bml_datapath #(
    .PRIME(PRIME)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .n_value  (n_value),
    .k_value  (k_value),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .binom_mod(binom_mod)
  );

endmodule

// ===== rtl/bml_divp.sv =====
`timescale 1ns / 1ps

module bml_divp #(
  parameter int PRIME = bml_pkg::PRIME_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  bml_pkg::op_t           in_op,
  input  logic [bml_pkg::XW-1:0] in_x,
  output logic                   busy,
  output logic                   wb_valid,
  output bml_pkg::op_t           wb_op,
  output logic [bml_pkg::XW-1:0] wb_q,
  output logic [$clog2(PRIME)-1:0] wb_r
);

  localparam int PW  = $clog2(PRIME);
  localparam int XW  = bml_pkg::XW;
  localparam int PQW = XW + PW;
  // floor(2^XW / PRIME): the quotient estimate is low by at most one
  localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / PRIME);

  logic [2*XW-1:0] prod1;
  logic [PQW-1:0]  prod2;
  logic [XW-1:0]   diff;
  logic            ge;

  logic            s1_v;
  bml_pkg::op_t    s1_op;
  logic [XW-1:0]   s1_x;
  logic [XW-1:0]   s1_q;

  logic            s2_v;
  bml_pkg::op_t    s2_op;
  logic [XW-1:0]   s2_x;
  logic [XW-1:0]   s2_q;
  logic [XW-1:0]   s2_qp;

  assign prod1 = (2*XW)'(in_x) * (2*XW)'(RECIP);
  assign prod2 = PQW'(s1_q) * PQW'(PRIME);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
      s2_v <= s1_v;
    end
    s1_op <= in_op;
    s1_x  <= in_x;
    s1_q  <= prod1[2*XW-1:XW];
    s2_op <= s1_op;
    s2_x  <= s1_x;
    s2_q  <= s1_q;
    s2_qp <= prod2[XW-1:0];
  end

  // remainder lands in [0, 2*PRIME): one correction step
  assign diff = s2_x - s2_qp;
  assign ge   = (diff >= XW'(PRIME));

  assign busy     = s1_v | s2_v;
  assign wb_valid = s2_v;
  assign wb_op    = s2_op;
  assign wb_q     = s2_q + XW'(ge);
  assign wb_r     = ge ? PW'(diff - XW'(PRIME)) : PW'(diff);

endmodule

// ===== rtl/bml_datapath.sv =====
`timescale 1ns / 1ps

module bml_datapath #(
  parameter int PRIME = bml_pkg::PRIME_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bml_pkg::cmd_t          cmd,
  output bml_pkg::status_t       status,
  input  logic [bml_pkg::XW-1:0] n_value,
  input  logic [bml_pkg::XW-1:0] k_value,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [bml_pkg::OW-1:0] binom_mod
);

  localparam int PW = $clog2(PRIME);
  localparam int XW = bml_pkg::XW;

  logic [PW-1:0] fact_mem [PRIME];
  logic [PW-1:0] invf_mem [PRIME];

  logic [PW-1:0] f_reg, p_reg, s_reg, e_reg, idx;
  logic [PW-1:0] nd, kd, nk, fa, ia, ib, t1, t2, acc;
  logic [XW-1:0] n_reg, k_reg;

  logic [PW-1:0]   op_a, op_b;
  logic [2*PW-1:0] prod;
  logic [XW-1:0]   x_next;

  logic            s0_v;
  bml_pkg::op_t    s0_op;
  logic [XW-1:0]   s0_x;

  logic            div_busy;
  logic            wb_valid;
  bml_pkg::op_t    wb_op;
  logic [XW-1:0]   wb_q;
  logic [PW-1:0]   wb_r;

  logic            fact_we, invf_we;
  logic [PW-1:0]   fact_wa, fact_wd, invf_wa, invf_wd;
  logic [bml_pkg::OW-1:0] result;

  // operand select for the shared modular unit
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    unique case (cmd.op) inside
      bml_pkg::OP_FACT: begin
        op_a = f_reg;
        op_b = idx;
      end
      bml_pkg::OP_PACC: begin
        op_a = p_reg;
        op_b = s_reg;
      end
      bml_pkg::OP_PSQ: begin
        op_a = s_reg;
        op_b = s_reg;
      end
      bml_pkg::OP_INVF: begin
        op_a = p_reg;
        op_b = idx;
      end
      bml_pkg::OP_MA: begin
        op_a = acc;
        op_b = fa;
      end
      bml_pkg::OP_MB: begin
        op_a = ia;
        op_b = ib;
      end
      bml_pkg::OP_MC: begin
        op_a = t1;
        op_b = t2;
      end
      bml_pkg::OP_DIVN, bml_pkg::OP_DIVK: begin
        op_a = '0;
        op_b = '0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = (2*PW)'(op_a) * (2*PW)'(op_b);

  always_comb begin
    case (cmd.op)
      bml_pkg::OP_DIVN: x_next = n_reg;
      bml_pkg::OP_DIVK: x_next = k_reg;
      default:          x_next = XW'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= cmd.issue;
    end
    s0_op <= cmd.op;
    s0_x  <= x_next;
  end

  bml_divp #(
    .PRIME(PRIME)
  ) u_divp (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s0_v),
    .in_op   (s0_op),
    .in_x    (s0_x),
    .busy    (div_busy),
    .wb_valid(wb_valid),
    .wb_op   (wb_op),
    .wb_q    (wb_q),
    .wb_r    (wb_r)
  );

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      f_reg <= PW'(1);
      idx   <= PW'(1);
    end
    if (cmd.idx_inc) begin
      idx <= idx + PW'(1);
    end
    if (cmd.idx_dec) begin
      idx <= idx - PW'(1);
    end
    if (cmd.pow_init) begin
      p_reg <= PW'(1);
      s_reg <= f_reg;
      e_reg <= PW'(PRIME - 2);
    end
    if (cmd.e_shift) begin
      e_reg <= e_reg >> 1;
    end
    if (cmd.load) begin
      n_reg <= n_value;
      k_reg <= k_value;
      acc   <= PW'(1);
    end
    if (cmd.acc_zero) begin
      acc <= '0;
    end
    if (wb_valid) begin
      unique case (wb_op)
        bml_pkg::OP_FACT: f_reg <= wb_r;
        bml_pkg::OP_PACC: p_reg <= wb_r;
        bml_pkg::OP_PSQ:  s_reg <= wb_r;
        bml_pkg::OP_INVF: p_reg <= wb_r;
        bml_pkg::OP_DIVN: begin
          n_reg <= wb_q;
          nd    <= wb_r;
        end
        bml_pkg::OP_DIVK: begin
          k_reg <= wb_q;
          kd    <= wb_r;
        end
        bml_pkg::OP_MA:   t1  <= wb_r;
        bml_pkg::OP_MB:   t2  <= wb_r;
        bml_pkg::OP_MC:   acc <= wb_r;
        default: ;
      endcase
    end
  end

  // table write ports
  always_comb begin
    fact_we = cmd.init || (wb_valid && (wb_op == bml_pkg::OP_FACT));
    fact_wa = cmd.init ? '0 : idx;
    fact_wd = cmd.init ? PW'(1) : wb_r;
    invf_we = cmd.seed || (wb_valid && (wb_op == bml_pkg::OP_INVF));
    invf_wa = cmd.seed ? idx : idx - PW'(1);
    invf_wd = cmd.seed ? p_reg : wb_r;
  end

  assign nk = nd - kd;

  always_ff @(posedge clk) begin
    if (fact_we) begin
      fact_mem[fact_wa] <= fact_wd;
    end
    if (cmd.rd) begin
      fa <= fact_mem[nd];
    end
  end

  always_ff @(posedge clk) begin
    if (invf_we) begin
      invf_mem[invf_wa] <= invf_wd;
    end
    if (cmd.rd) begin
      ia <= invf_mem[kd];
      ib <= invf_mem[nk];
    end
  end

  // output register: a finished result waits here for its transfer
  assign result = bml_pkg::OW'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      binom_mod <= result;
    end
  end

  always_comb begin
    status.busy     = s0_v | div_busy;
    status.idx_last = (idx == PW'(PRIME - 1));
    status.idx_one  = (idx == PW'(1));
    status.e_zero   = (e_reg == '0);
    status.e_bit0   = e_reg[0];
    status.k_zero   = (k_reg == '0);
    status.kd_gt_nd = (kd > nd);
    status.out_free = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/bml_ctrl.sv =====
`timescale 1ns / 1ps

module bml_ctrl #(
  parameter int MAX_DIGITS = bml_pkg::MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output bml_pkg::cmd_t    cmd,
  input  bml_pkg::status_t status
);

  localparam int DW = $clog2(MAX_DIGITS + 1);

  bml_pkg::state_t state, state_next;
  logic [DW-1:0]   dig, dig_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bml_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
    dig <= dig_next;
  end

  assign in_stall = (state != bml_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    dig_next   = dig;
    cmd        = '0;
    unique case (state)
      bml_pkg::ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = bml_pkg::ST_FACT_ISSUE;
      end
      bml_pkg::ST_FACT_ISSUE: begin
        cmd.issue  = 1'b1;
        cmd.op     = bml_pkg::OP_FACT;
        state_next = bml_pkg::ST_FACT_WAIT;
      end
      bml_pkg::ST_FACT_WAIT: begin
        if (!status.busy) begin
          if (status.idx_last) begin
            state_next = bml_pkg::ST_POW_INIT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = bml_pkg::ST_FACT_ISSUE;
          end
        end
      end
      bml_pkg::ST_POW_INIT: begin
        cmd.pow_init = 1'b1;
        state_next   = bml_pkg::ST_POW_CHECK;
      end
      bml_pkg::ST_POW_CHECK: begin
        if (status.e_zero) begin
          state_next = bml_pkg::ST_SEED;
        end else begin
          cmd.issue  = status.e_bit0;
          cmd.op     = bml_pkg::OP_PACC;
          state_next = bml_pkg::ST_POW_SQ;
        end
      end
      bml_pkg::ST_POW_SQ: begin
        cmd.issue   = 1'b1;
        cmd.op      = bml_pkg::OP_PSQ;
        cmd.e_shift = 1'b1;
        state_next  = bml_pkg::ST_POW_WAIT;
      end
      bml_pkg::ST_POW_WAIT: begin
        if (!status.busy) begin
          state_next = bml_pkg::ST_POW_CHECK;
        end
      end
      bml_pkg::ST_SEED: begin
        cmd.seed   = 1'b1;
        state_next = bml_pkg::ST_INVF_ISSUE;
      end
      bml_pkg::ST_INVF_ISSUE: begin
        cmd.issue  = 1'b1;
        cmd.op     = bml_pkg::OP_INVF;
        state_next = bml_pkg::ST_INVF_WAIT;
      end
      bml_pkg::ST_INVF_WAIT: begin
        if (!status.busy) begin
          if (status.idx_one) begin
            state_next = bml_pkg::ST_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_next  = bml_pkg::ST_INVF_ISSUE;
          end
        end
      end
      bml_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          dig_next   = '0;
          state_next = bml_pkg::ST_DIG_CHECK;
        end
      end
      bml_pkg::ST_DIG_CHECK: begin
        if (status.k_zero || (dig == DW'(MAX_DIGITS))) begin
          state_next = bml_pkg::ST_DONE;
        end else begin
          cmd.issue  = 1'b1;
          cmd.op     = bml_pkg::OP_DIVN;
          state_next = bml_pkg::ST_DIV_K;
        end
      end
      bml_pkg::ST_DIV_K: begin
        cmd.issue  = 1'b1;
        cmd.op     = bml_pkg::OP_DIVK;
        state_next = bml_pkg::ST_DIV_WAIT;
      end
      bml_pkg::ST_DIV_WAIT: begin
        if (!status.busy) begin
          state_next = bml_pkg::ST_READ;
        end
      end
      bml_pkg::ST_READ: begin
        // a digit of k above the digit of n zeroes the whole product
        if (status.kd_gt_nd) begin
          cmd.acc_zero = 1'b1;
          state_next   = bml_pkg::ST_DONE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = bml_pkg::ST_MUL_AB;
        end
      end
      bml_pkg::ST_MUL_AB: begin
        cmd.issue  = 1'b1;
        cmd.op     = bml_pkg::OP_MA;
        state_next = bml_pkg::ST_MUL_B;
      end
      bml_pkg::ST_MUL_B: begin
        cmd.issue  = 1'b1;
        cmd.op     = bml_pkg::OP_MB;
        state_next = bml_pkg::ST_MUL_WAIT1;
      end
      bml_pkg::ST_MUL_WAIT1: begin
        if (!status.busy) begin
          state_next = bml_pkg::ST_MUL_C;
        end
      end
      bml_pkg::ST_MUL_C: begin
        cmd.issue  = 1'b1;
        cmd.op     = bml_pkg::OP_MC;
        state_next = bml_pkg::ST_MUL_WAIT2;
      end
      bml_pkg::ST_MUL_WAIT2: begin
        if (!status.busy) begin
          dig_next   = dig + DW'(1);
          state_next = bml_pkg::ST_DIG_CHECK;
        end
      end
      bml_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bml_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bml_pkg::ST_INIT;
      end
    endcase
  end

endmodule
